>>> rtl/bm25_score_accumulator_defines.svh
// assertion macros shared by the checker
`ifndef BM25_SCORE_ACCUMULATOR_DEFINES_SVH
`define BM25_SCORE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
        else $error("bm25 score accumulator check failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> cons) \
        else $error("bm25 score accumulator check failed");

`endif

>>> rtl/bsa_pkg.sv
// shared types and constants of the bm25 score accumulator
package bsa_pkg;

    localparam int DOC_BITS     = 16;
    localparam int MAX_DOCS     = 1 << DOC_BITS;
    localparam int CLR_BITS     = DOC_BITS + 1;
    localparam int LEN_BITS     = 16;
    localparam int VAL_BITS     = 16;
    localparam int OP_BITS      = 2;
    localparam int SCORE_BITS   = 32;
    localparam int IN_BITS      = 40;
    localparam int OP_LSB       = 0;
    localparam int DOC_LSB      = OP_LSB + OP_BITS;
    localparam int VAL_LSB      = DOC_LSB + DOC_BITS;
    localparam int CFG_BITS     = 24;
    localparam int DIV_BITS     = 64;
    localparam int DIV_CNT_BITS = 7;
    localparam int LOG_IN_BITS  = 18;
    localparam int LOG_E_BITS   = 5;
    localparam int FRAC_BITS    = 16;
    localparam int LOG_OUT_BITS = LOG_E_BITS + FRAC_BITS;
    localparam int MANT_BITS    = 32;
    localparam int IDF_BITS     = LOG_OUT_BITS + 1;
    localparam int NORM_BITS    = 38;
    localparam int NORM_HALF    = 19;
    localparam int DEN_BITS     = 55;
    localparam int NUM_BITS     = 33;
    localparam int BIJ_BITS     = 21;
    localparam int WMAG_BITS    = 26;
    localparam int SUM_BITS     = SCORE_BITS + 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD_LEN,
        OP_START_TERM,
        OP_POSTING,
        OP_READ_SCORE
    } op_t;

    typedef enum logic [1:0] {
        CFG_K1,
        CFG_B,
        CFG_N,
        CFG_AVG
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOG_A,
        ST_LOG_AW,
        ST_LOG_B,
        ST_LOG_BW,
        ST_NORM,
        ST_NORM_W,
        ST_DEN_LO,
        ST_DEN_HI,
        ST_BIJ,
        ST_BIJ_W,
        ST_WEIGHT,
        ST_ACC,
        ST_READ
    } bsa_state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [LOG_IN_BITS-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic                    done;
        logic [LOG_OUT_BITS-1:0] result;
    } log_rsp_t;

endpackage

>>> rtl/bm25_score_accumulator.sv
// top level of the bm25 score accumulator
//
// Items arrive as beats on the s_ channel: op, doc_id and value. Op 0 stores a
// document length, op 1 starts a term and works out its idf, op 2 adds a
// posting's weight to the document's score, op 3 returns the score on the m_
// channel and clears it. Registers k1, b, doc count and average length are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no item is in flight, which the block does not enforce. A
// posting that repeats the term's previous document is dropped. s_tready is
// low while an item is in flight: op 1 makes two passes through the log unit
// (one squaring multiply per fraction bit), op 2 two passes through the shared
// divider at one quotient bit per cycle, and op 3 waits for the output register.
// Scores and lengths sit in two single-port synchronous memories, one read
// and at most one write per item, with read data registered.
// After reset the score memory is swept to zero, one entry a cycle over all
// 65536 entries, with s_tready low; lengths are not cleared.
// The result waits in an output register; a stalled receiver only holds up a
// following op 3, other ops go on.
module bm25_score_accumulator
    import bsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_BITS-1:0]    s_tdata,   // op[1:0], doc_id[17:2], value[33:18], zeros
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SCORE_BITS-1:0] m_tdata,   // score[31:0]
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    bsa_state_t state_reg, state_next;

    logic [15:0]             k1_reg;
    logic [12:0]             b_reg;
    logic [16:0]             n_reg;
    logic [23:0]             avg_reg;

    logic [CLR_BITS-1:0]     clr_cnt_reg;
    logic [DOC_BITS-1:0]     doc_reg;
    logic [VAL_BITS-1:0]     val_reg;
    logic [DOC_BITS-1:0]     prev_doc_reg;
    logic                    first_reg;
    logic [LOG_OUT_BITS-1:0] la_reg;
    logic                    idf_neg_reg;
    logic [LOG_OUT_BITS-1:0] idf_mag_reg;
    logic [NORM_BITS-1:0]    norm_reg;
    logic [34:0]             plo_reg;
    logic [DEN_BITS-1:0]     den_reg;
    logic [NUM_BITS-1:0]     num_reg;
    logic [BIJ_BITS-1:0]     bij_reg;
    logic [WMAG_BITS-1:0]    wmag_reg;
    logic                    m_tvalid_reg;
    logic [SCORE_BITS-1:0]   m_tdata_reg;

    logic [LEN_BITS-1:0]     len_mem [MAX_DOCS];
    logic [SCORE_BITS-1:0]   score_mem [MAX_DOCS];
    logic [LEN_BITS-1:0]     len_rd_reg;
    logic [SCORE_BITS-1:0]   score_rd_reg;

    op_t                     op_in;
    logic [DOC_BITS-1:0]     doc_in;
    logic [VAL_BITS-1:0]     val_in;
    logic                    accept;
    logic                    dup;
    logic                    out_free;
    logic                    out_load;
    logic                    score_we;
    logic [DOC_BITS-1:0]     score_wa;
    logic [SCORE_BITS-1:0]   score_wd;

    logic [12:0]             b_eff;
    logic [23:0]             a_eff;
    logic [16:0]             df;
    logic [IDF_BITS-1:0]     idf_diff;
    logic [SUM_BITS-1:0]     wsum;
    logic [SUM_BITS-1:0]     w_ext;
    logic [SCORE_BITS-1:0]   sat_sum;
    logic [BIJ_BITS+LOG_OUT_BITS-1:0] w_prod;

    div_req_t                div_req;
    div_rsp_t                div_rsp;
    log_req_t                log_req;
    log_rsp_t                log_rsp;

    bsa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bsa_log2 u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    assign op_in    = op_t'(s_tdata[OP_LSB +: OP_BITS]);
    assign doc_in   = s_tdata[DOC_LSB +: DOC_BITS];
    assign val_in   = s_tdata[VAL_LSB +: VAL_BITS];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign dup      = !first_reg && (doc_in == prev_doc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_READ) && out_free;

    assign b_eff = (b_reg > 13'd4096) ? 13'd4096 : b_reg;
    assign a_eff = (avg_reg == '0) ? 24'd1 : avg_reg;
    assign df    = (17'(val_reg) > n_reg) ? n_reg : 17'(val_reg);

    assign idf_diff = {1'b0, la_reg} - {1'b0, log_rsp.result};

    assign w_prod = bij_reg * idf_mag_reg;

    assign w_ext = idf_neg_reg ? (SUM_BITS'(0) - SUM_BITS'(wmag_reg)) : SUM_BITS'(wmag_reg);
    assign wsum  = {{2{score_rd_reg[SCORE_BITS-1]}}, score_rd_reg} + w_ext;

    always_comb
    begin
        if (wsum[SUM_BITS-1:SCORE_BITS-1] == '0 || wsum[SUM_BITS-1:SCORE_BITS-1] == '1)
        begin
            sat_sum = wsum[SCORE_BITS-1:0];
        end
        else if (wsum[SUM_BITS-1])
        begin
            sat_sum = {1'b1, {(SCORE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(SCORE_BITS-1){1'b1}}};
        end
    end

    // request to the shared units
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {27'b0, 29'(b_eff) * 29'(len_rd_reg), 8'b0};
        div_req.divisor  = {40'b0, a_eff};
        log_req.start    = 1'b0;
        log_req.x        = {n_reg - df, 1'b1};
        case (state_reg)
            ST_NORM:
            begin
                div_req.start = 1'b1;
            end
            ST_BIJ:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {3'b0, num_reg, 28'b0};
                div_req.divisor  = {9'b0, den_reg};
            end
            ST_LOG_A:
            begin
                log_req.start = 1'b1;
            end
            ST_LOG_B:
            begin
                log_req.start = 1'b1;
                log_req.x     = {df, 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        score_we   = 1'b0;
        score_wa   = doc_reg;
        score_wd   = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                score_we = 1'b1;
                score_wa = clr_cnt_reg[DOC_BITS-1:0];
                if (clr_cnt_reg == CLR_BITS'(MAX_DOCS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_START_TERM: state_next = ST_LOG_A;
                        OP_POSTING:    state_next = dup ? ST_IDLE : ST_NORM;
                        OP_READ_SCORE: state_next = ST_READ;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOG_A:  state_next = ST_LOG_AW;
            ST_LOG_AW: state_next = log_rsp.done ? ST_LOG_B : ST_LOG_AW;
            ST_LOG_B:  state_next = ST_LOG_BW;
            ST_LOG_BW: state_next = log_rsp.done ? ST_IDLE : ST_LOG_BW;
            ST_NORM:   state_next = ST_NORM_W;
            ST_NORM_W: state_next = div_rsp.done ? ST_DEN_LO : ST_NORM_W;
            ST_DEN_LO: state_next = ST_DEN_HI;
            ST_DEN_HI: state_next = ST_BIJ;
            ST_BIJ:    state_next = ST_BIJ_W;
            ST_BIJ_W:  state_next = div_rsp.done ? ST_WEIGHT : ST_BIJ_W;
            ST_WEIGHT: state_next = ST_ACC;
            ST_ACC:
            begin
                score_we   = 1'b1;
                score_wd   = sat_sum;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    score_we   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            k1_reg       <= 16'd410;
            b_reg        <= 13'd1966;
            n_reg        <= 17'd1;
            avg_reg      <= 24'd256;
            prev_doc_reg <= '0;
            first_reg    <= 1'b1;
            idf_neg_reg  <= 1'b0;
            idf_mag_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_K1:  k1_reg  <= cfg_data[15:0];
                    CFG_B:   b_reg   <= cfg_data[12:0];
                    CFG_N:   n_reg   <= cfg_data[16:0];
                    CFG_AVG: avg_reg <= cfg_data[23:0];
                    default: k1_reg  <= k1_reg;
                endcase
            end
            if (accept && op_in == OP_START_TERM)
            begin
                first_reg <= 1'b1;
            end
            else if (accept && op_in == OP_POSTING && !dup)
            begin
                first_reg    <= 1'b0;
                prev_doc_reg <= doc_in;
            end
            if (state_reg == ST_LOG_BW && log_rsp.done)
            begin
                idf_neg_reg <= idf_diff[IDF_BITS-1];
                idf_mag_reg <= idf_diff[IDF_BITS-1] ?
                               LOG_OUT_BITS'(IDF_BITS'(0) - idf_diff) :
                               idf_diff[LOG_OUT_BITS-1:0];
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            doc_reg <= doc_in;
            val_reg <= val_in;
        end
        if (state_reg == ST_LOG_AW && log_rsp.done)
        begin
            la_reg <= log_rsp.result;
        end
        if (state_reg == ST_NORM_W && div_rsp.done)
        begin
            norm_reg <= NORM_BITS'(13'd4096 - b_eff) + NORM_BITS'(div_rsp.quotient[36:0]);
        end
        if (state_reg == ST_DEN_LO)
        begin
            plo_reg <= k1_reg * norm_reg[NORM_HALF-1:0];
            num_reg <= (17'(k1_reg) + 17'd4096) * val_reg;
        end
        if (state_reg == ST_DEN_HI)
        begin
            den_reg <= (DEN_BITS'(k1_reg * norm_reg[NORM_BITS-1:NORM_HALF]) << NORM_HALF)
                       + DEN_BITS'(plo_reg) + (DEN_BITS'(val_reg) << 24);
        end
        if (state_reg == ST_BIJ_W && div_rsp.done)
        begin
            bij_reg <= (den_reg == '0) ? '0 : div_rsp.quotient[BIJ_BITS-1:0];
        end
        if (state_reg == ST_WEIGHT)
        begin
            wmag_reg <= w_prod[FRAC_BITS +: WMAG_BITS];
        end
        if (out_load)
        begin
            m_tdata_reg <= score_rd_reg;
        end
    end

    // length and score memories
    always_ff @(posedge clk)
    begin
        if (accept && op_in == OP_LOAD_LEN)
        begin
            len_mem[doc_in] <= val_in;
        end
        if (accept)
        begin
            len_rd_reg <= len_mem[doc_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (score_we)
        begin
            score_mem[score_wa] <= score_wd;
        end
        if (accept)
        begin
            score_rd_reg <= score_mem[doc_in];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/bsa_divider.sv
// restoring divider, one quotient bit per cycle
module bsa_divider
    import bsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS-1:0]     quo_reg;
    logic [DIV_BITS-1:0]     rem_reg;
    logic [DIV_BITS-1:0]     dvs_reg;
    logic [DIV_BITS:0]       rem_shift;
    logic [DIV_BITS:0]       diff;

    assign rem_shift = {rem_reg, quo_reg[DIV_BITS-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_BITS])
            begin
                rem_reg <= diff[DIV_BITS-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DIV_BITS-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/bsa_log2.sv
// log2 of a positive integer in q5.16 by repeated squaring
module bsa_log2
    import bsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  log_req_t req,
    output log_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [3:0]              cnt_reg;
    logic [MANT_BITS-1:0]    m_reg;
    logic [LOG_E_BITS-1:0]   e_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [LOG_E_BITS-1:0]   msb;
    logic [MANT_BITS-1:0]    m_start;
    logic [2*MANT_BITS-1:0]  prod;
    logic [MANT_BITS:0]      sq;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < LOG_IN_BITS; i++)
        begin
            if (req.x[i])
            begin
                msb = LOG_E_BITS'(i);
            end
        end
        m_start = MANT_BITS'(req.x) << (LOG_E_BITS'(MANT_BITS - 1) - msb);
    end

    assign prod = m_reg * m_reg;
    assign sq   = prod[2*MANT_BITS-1:MANT_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'(FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            m_reg    <= m_start;
            e_reg    <= msb;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (sq[MANT_BITS])
            begin
                m_reg    <= sq[MANT_BITS:1];
                frac_reg <= {frac_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                m_reg    <= sq[MANT_BITS-1:0];
                frac_reg <= {frac_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {e_reg, frac_reg};

endmodule

>>> rtl/bsa_checker.sv
// port checks of the bm25 score accumulator
`include "bm25_score_accumulator_defines.svh"

module bsa_checker
    import bsa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_BITS-1:0]    s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [SCORE_BITS-1:0] m_tdata
);

    `BSA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BSA_ASSERT_NEXT(a_term_busy, clk, rst_n, s_tvalid && s_tready && s_tdata[1:0] == OP_START_TERM, !s_tready)
    `BSA_ASSERT_IMP(a_read_lat, clk, rst_n, s_tvalid && s_tready && s_tdata[1:0] == OP_READ_SCORE && !m_tvalid, ##2 m_tvalid)

endmodule

bind bm25_score_accumulator bsa_checker u_bsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_bm25_score_accumulator.sv
// self-checking bm25 score accumulator testbench: directed table, random term runs, saturation
module tb_bm25_score_accumulator;
    import bsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        op_t         op;
        bit [15:0]   doc;
        bit [15:0]   val;
        bit          typed;
        bit [31:0]   score;
    } stim_row_t;

    typedef struct {
        bit [15:0] k1;
        bit [12:0] b;
        bit [16:0] n;
        bit [23:0] avg;
    } cfg_set_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_BITS-1:0]    s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SCORE_BITS-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;

    // predictor state
    bit [15:0]   k1_reg = 16'd410;
    bit [12:0]   b_reg = 13'd1966;
    bit [16:0]   n_reg = 17'd1;
    bit [23:0]   avg_reg = 24'd256;
    bit [15:0]   doc_len [int];
    longint      doc_score [int];
    longint      idf_now = 0;
    bit [15:0]   last_doc = '0;
    bit          term_fresh = 1'b1;

    bit [31:0]   score_queue [$];
    int          loaded_docs [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          stall_mode = 0;
    int          n_items = 0;
    int          n_postings = 0;
    int          n_terms = 0;
    int          n_scores = 0;
    int          n_sat = 0;

    bm25_score_accumulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_scores++;
            if (score_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected score beat %h", m_tdata);
            end
            else
            begin
                if (m_tdata !== score_queue[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("score mismatch: expected %h got %h", score_queue[0], m_tdata);
                end
                void'(score_queue.pop_front());
            end
        end
    end

    function automatic longint log2_fix(longint unsigned x);
        int              e;
        longint unsigned m;
        longint          frac;
        e = 0;
        frac = 0;
        if (x == 0)
            return 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(e) * 65536 + frac;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // bm25 weight of one posting, added into the document's score
    function automatic void add_posting(bit [15:0] doc, bit [15:0] tf);
        longint unsigned k, b, a, len, norm, den, num, bij, mag;
        longint          sum;
        k = k1_reg;
        b = (b_reg > 4096) ? 4096 : b_reg;
        a = (avg_reg == 0) ? 1 : avg_reg;
        len = doc_len.exists(doc) ? doc_len[doc] : 0;
        norm = (4096 - b) + (b * len * 256) / a;
        den = k * norm + (longint'(tf) << 24);
        num = (k + 4096) * tf;
        bij = (den == 0) ? 0 : (num << 28) / den;
        mag = (idf_now < 0) ? -idf_now : idf_now;
        mag = (bij * mag) >> 16;
        sum = doc_score.exists(doc) ? doc_score[doc] : 0;
        sum = sum + ((idf_now < 0) ? -longint'(mag) : longint'(mag));
        if (sum != clamp32(sum))
            n_sat++;
        doc_score[doc] = clamp32(sum);
    endfunction

    function automatic void predict_item(op_t op, bit [15:0] doc, bit [15:0] val,
                                         bit typed, bit [31:0] typed_score);
        longint unsigned df;
        longint          s;
        case (op)
            OP_LOAD_LEN:
                doc_len[doc] = val;
            OP_START_TERM:
            begin
                df = (val > n_reg) ? n_reg : val;
                idf_now = log2_fix(2 * (n_reg - df) + 1) - log2_fix(2 * df + 1);
                term_fresh = 1'b1;
                n_terms++;
            end
            OP_POSTING:
            begin
                if (term_fresh || doc != last_doc)
                begin
                    term_fresh = 1'b0;
                    last_doc = doc;
                    add_posting(doc, val);
                end
                n_postings++;
            end
            default:
            begin
                s = doc_score.exists(doc) ? doc_score[doc] : 0;
                doc_score[doc] = 0;
                score_queue = {score_queue, (typed ? typed_score : 32'(clamp32(s)))};
            end
        endcase
    endfunction

    task automatic send_item(op_t op, bit [15:0] doc, bit [15:0] val,
                             bit typed = 1'b0, bit [31:0] typed_score = '0);
        if (gaps_on && burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tdata = {6'b0, val, doc, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(op, doc, val, typed, typed_score);
        if (op == OP_LOAD_LEN)
            loaded_docs = {loaded_docs, int'(doc)};
        n_items++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (score_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, bit [23:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_K1: k1_reg = data[15:0];
            CFG_B: b_reg = data[12:0];
            CFG_N: n_reg = data[16:0];
            default: avg_reg = data;
        endcase
    endtask

    task automatic load_config(cfg_set_t c);
        write_reg(CFG_K1, 24'(c.k1));
        write_reg(CFG_B, 24'(c.b));
        write_reg(CFG_N, 24'(c.n));
        write_reg(CFG_AVG, c.avg);
    endtask

    function automatic bit [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] pick_loaded();
        return 16'(loaded_docs[$urandom_range(0, loaded_docs.size() - 1)]);
    endfunction

    // a term run: start, a few postings with the odd repeat, then at most one read
    task automatic term_run();
        bit [15:0] doc;
        bit [15:0] posted [$];
        int        np;
        send_item(OP_START_TERM, 16'h0, rand_field());
        np = $urandom_range(1, 8);
        for (int i = 0; i < np; i++)
        begin
            if (posted.size() != 0 && $urandom_range(0, 5) == 0)
                doc = posted[$];
            else
                doc = pick_loaded();
            posted = {posted, doc};
            send_item(OP_POSTING, doc, rand_field());
        end
        if ($urandom_range(0, 1))
            send_item(OP_READ_SCORE, posted[$urandom_range(0, posted.size() - 1)],
                      16'($urandom));
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send_item(OP_LOAD_LEN, 16'($urandom), rand_field());
            1: send_item(OP_READ_SCORE, 16'($urandom), 16'($urandom));
            2: send_item(OP_READ_SCORE, pick_loaded(), 16'($urandom));
            default: send_item(OP_POSTING, pick_loaded(), rand_field());
        endcase
    endtask

    stim_row_t directed [] = '{
        '{OP_READ_SCORE, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
        '{OP_READ_SCORE, 16'hffff, 16'hffff, 1'b1, 32'h0000_0000},
        '{OP_LOAD_LEN,   16'h0000, 16'h0000, 1'b0, '0},
        '{OP_LOAD_LEN,   16'hffff, 16'hffff, 1'b0, '0},
        '{OP_LOAD_LEN,   16'h0001, 16'h0100, 1'b0, '0},
        '{OP_START_TERM, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_POSTING,    16'h0001, 16'hffff, 1'b0, '0},
        '{OP_POSTING,    16'h0001, 16'h0005, 1'b0, '0},
        '{OP_POSTING,    16'hffff, 16'h0000, 1'b0, '0},
        '{OP_POSTING,    16'h0000, 16'h0001, 1'b0, '0},
        '{OP_START_TERM, 16'h0000, 16'hffff, 1'b0, '0},
        '{OP_POSTING,    16'h0001, 16'h0003, 1'b0, '0},
        '{OP_POSTING,    16'hffff, 16'hffff, 1'b0, '0},
        '{OP_READ_SCORE, 16'h0001, 16'h0000, 1'b0, '0},
        '{OP_READ_SCORE, 16'h0001, 16'h0000, 1'b1, 32'h0000_0000},
        '{OP_READ_SCORE, 16'hffff, 16'h0000, 1'b0, '0},
        '{OP_READ_SCORE, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_READ_SCORE, 16'h1234, 16'h0000, 1'b1, 32'h0000_0000}
    };

    cfg_set_t phases [] = '{
        '{16'd0,     13'd0,    17'd1,      24'd0},
        '{16'd65535, 13'd4096, 17'd65536,  24'd1},
        '{16'd4096,  13'd8191, 17'd131071, 24'd16777215},
        '{16'd1228,  13'd3000, 17'd1000,   24'd2560},
        '{16'd0,     13'd4096, 17'd0,      24'd256},
        '{16'd700,   13'd500,  17'd50000,  24'd40000}
    };

    initial
    begin
        cfg_set_t sat_cfg;
        bit [15:0] sat_doc;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_item(directed[i].op, directed[i].doc, directed[i].val,
                      directed[i].typed, directed[i].score);
        wait_idle();

        foreach (phases[p])
        begin
            load_config(phases[p]);
            stall_mode = p % 3;
            gaps_on = (p != 2);
            for (int i = 0; i < 4; i++)
                send_item(OP_LOAD_LEN, 16'($urandom), rand_field());
            for (int i = 0; i < 8; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    noise_item();
                else
                    term_run();
            end
            wait_idle();
        end

        // push one document's score up to the top and then down to the bottom
        sat_cfg = '{16'd65535, 13'd0, 17'd65536, 24'd256};
        load_config(sat_cfg);
        stall_mode = 1;
        sat_doc = 16'h0001;
        for (int i = 0; i < 130; i++)
        begin
            send_item(OP_START_TERM, 16'h0, 16'h0001);
            send_item(OP_POSTING, sat_doc, 16'hffff);
        end
        send_item(OP_READ_SCORE, sat_doc, 16'h0, 1'b1, 32'h7fff_ffff);
        for (int i = 0; i < 260; i++)
        begin
            send_item(OP_START_TERM, 16'h0, 16'hffff);
            send_item(OP_POSTING, sat_doc, 16'hffff);
        end
        send_item(OP_READ_SCORE, sat_doc, 16'h0, 1'b1, 32'h8000_0000);
        wait_idle();

        $display("%0d items: %0d terms, %0d postings, %0d score beats, %0d saturating adds",
                 n_items, n_terms, n_postings, n_scores, n_sat);
        $display("%0d register settings incl. zero, full-scale and clamped values",
                 phases.size() + 2);
        if (errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> bm25_score_accumulator.f
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_divider.sv
rtl/bsa_log2.sv
rtl/bm25_score_accumulator.sv
rtl/bsa_checker.sv
tb/tb_bm25_score_accumulator.sv
